/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master status sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // default width of the transfer byte counters
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // field widths
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = LEN_W;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 2 * BYTE_W;
  localparam int unsigned IN_TUSER_W  = 1 + STATUS_W;
  localparam int unsigned OUT_TDATA_W = 32;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAVE_ADDR = 2'd0,
    REG_TX_LENGTH  = 2'd1,
    REG_RX_LENGTH  = 2'd2
  } cfg_reg_t;

  // request kind
  typedef enum logic {
    OP_START  = 1'b0,
    OP_STATUS = 1'b1
  } op_t;

  // controller status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_START     = 4'd0,
    ST_SLAW_ACK  = 4'd1,
    ST_SLAW_NACK = 4'd2,
    ST_TDAT_ACK  = 4'd3,
    ST_TDAT_NACK = 4'd4,
    ST_SLAR_ACK  = 4'd5,
    ST_SLAR_NACK = 4'd6,
    ST_RDAT_ACK  = 4'd7,
    ST_RDAT_NACK = 4'd8,
    ST_ARB_LOST  = 4'd9,
    ST_BUS_ERROR = 4'd10,
    ST_OTHER     = 4'd11
  } status_t;

  // error kinds
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_ARB  = 2'd1,
    ERR_BUS  = 2'd2,
    ERR_ACK  = 2'd3
  } err_t;

  // configuration register set
  typedef struct packed {
    logic [ADDR_W-1:0] slave_address;
    logic [LEN_W-1:0]  tx_length;
    logic [LEN_W-1:0]  rx_length;
  } cfg_t;

  // one input request
  typedef struct packed {
    op_t               operation;
    status_t           status_code;
    logic [BYTE_W-1:0] rx_data;
    logic [BYTE_W-1:0] tx_data;
  } req_t;

  // one result, last field in the lowest bits
  typedef struct packed {
    err_t              error_kind;
    logic              finished;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              clear_event;
    logic              clear_ack;
    logic              set_ack;
    logic              set_stop;
    logic              set_start;
    logic              write_byte;
    logic [BYTE_W-1:0] bus_byte;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

/* rtl/i2cms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// i2cms_cfg_regs
// Configuration registers: slave address and transfer lengths.
// ----------------------------------------------------------------------------
module i2cms_cfg_regs
  import i2cms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SLAVE_ADDR: cfg_nxt.slave_address = cfg_wdata[ADDR_W-1:0];
        REG_TX_LENGTH:  cfg_nxt.tx_length     = cfg_wdata[LEN_W-1:0];
        REG_RX_LENGTH:  cfg_nxt.rx_length     = cfg_wdata[LEN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/i2cms_step.sv */
// ----------------------------------------------------------------------------
// i2cms_step
// Per-request decode: bus actions and next transmit and receive counts.
// ----------------------------------------------------------------------------
module i2cms_step
  import i2cms_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
)(
  input  req_t                   req,
  input  cfg_t                   cfg,
  input  logic [LENGTH_BITS-1:0] tx_rem,
  input  logic [LENGTH_BITS-1:0] rx_rem,
  output res_t                   res,
  output logic [LENGTH_BITS-1:0] tx_rem_nxt,
  output logic [LENGTH_BITS-1:0] rx_rem_nxt
);

  localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

  logic                   tx_nz;
  logic                   rx_nz;
  logic [LENGTH_BITS-1:0] rx_dec;
  logic [31:0]            tx_len_ext;
  logic [31:0]            rx_len_ext;

  assign tx_nz      = |tx_rem;
  assign rx_nz      = |rx_rem;
  // receive count saturates at zero
  assign rx_dec     = rx_nz ? rx_rem - CNT_ONE : rx_rem;
  assign tx_len_ext = {16'b0, cfg.tx_length};
  assign rx_len_ext = {16'b0, cfg.rx_length};

  // decode one request
  always_comb begin
    res        = '0;
    res.error_kind = ERR_NONE;
    tx_rem_nxt = tx_rem;
    rx_rem_nxt = rx_rem;
    if (req.operation == OP_START) begin
      tx_rem_nxt    = tx_len_ext[LENGTH_BITS-1:0];
      rx_rem_nxt    = rx_len_ext[LENGTH_BITS-1:0];
      res.set_start = 1'b1;
    end else begin
      case (req.status_code)
        ST_START: begin
          // address byte, read bit once nothing is left to send
          res.bus_byte    = {cfg.slave_address, ~tx_nz};
          res.write_byte  = 1'b1;
          res.clear_event = 1'b1;
        end
        ST_SLAW_NACK, ST_TDAT_NACK, ST_SLAR_NACK: begin
          res.set_stop    = 1'b1;
          res.clear_event = 1'b1;
          res.finished    = 1'b1;
          res.error_kind  = ERR_ACK;
        end
        ST_SLAW_ACK, ST_TDAT_ACK: begin
          res.clear_event = 1'b1;
          if (tx_nz) begin
            res.bus_byte   = req.tx_data;
            res.write_byte = 1'b1;
            tx_rem_nxt     = tx_rem - CNT_ONE;
          end else if (rx_nz) begin
            // repeated start for the read phase
            res.set_stop  = 1'b1;
            res.set_start = 1'b1;
          end else begin
            res.set_stop = 1'b1;
            res.finished = 1'b1;
          end
        end
        ST_SLAR_ACK: begin
          res.clear_event = 1'b1;
          res.clear_ack   = (rx_rem == CNT_ONE);
          res.set_ack     = (rx_rem != CNT_ONE);
        end
        ST_RDAT_ACK: begin
          res.rx_byte     = req.rx_data;
          res.rx_valid    = 1'b1;
          rx_rem_nxt      = rx_dec;
          res.clear_event = 1'b1;
          res.clear_ack   = (rx_dec == CNT_ONE);
          res.set_ack     = (rx_dec != CNT_ONE);
        end
        ST_RDAT_NACK: begin
          res.rx_byte     = req.rx_data;
          res.rx_valid    = 1'b1;
          rx_rem_nxt      = rx_dec;
          res.set_stop    = 1'b1;
          res.clear_event = 1'b1;
          res.finished    = 1'b1;
        end
        ST_ARB_LOST: begin
          res.clear_event = 1'b1;
          res.finished    = 1'b1;
          res.error_kind  = ERR_ARB;
        end
        ST_BUS_ERROR: begin
          res.clear_event = 1'b1;
          res.finished    = 1'b1;
          res.error_kind  = ERR_BUS;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

/* rtl/i2c_master_status_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer_core
// Sequences an I2C master transfer one controller status event at a time.
// ----------------------------------------------------------------------------
// A start request loads the transmit and receive byte counts from the length
// registers and asks for START; each status event request then returns the
// controller actions (address or data byte, START, STOP, ACK control, event
// clear), any received byte and the end-of-transfer flag with its error kind.
// Every request gives exactly one result. A request is latched in an input
// register, decoded combinationally against the live byte counters and the
// result is held in an output register, so one request is taken per clock
// while the input side is not stalled; the input side only stalls while the
// output register holds a result not yet taken.
// Write the configuration registers only while no request is in flight.
module i2c_master_status_sequencer_core
  import i2cms_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // rx_data[7:0], tx_data[15:8]
  input  logic [IN_TUSER_W-1:0]  in_tuser,  // operation[0], status_code[4:1]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // bus_byte[7:0], write_byte[8], set_start[9], set_stop[10], set_ack[11],
  // clear_ack[12], clear_event[13], rx_byte[21:14], rx_valid[22],
  // finished[23], error_kind[25:24], zero fill[31:26]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t                   cfg;
  req_t                   req_r;
  logic                   req_v_r;
  logic                   req_v_nxt;
  res_t                   res;
  res_t                   res_r;
  logic                   res_v_r;
  logic                   res_v_nxt;
  logic                   advance;
  logic                   fire;
  logic [LENGTH_BITS-1:0] tx_rem_r;
  logic [LENGTH_BITS-1:0] rx_rem_r;
  logic [LENGTH_BITS-1:0] tx_rem_nxt;
  logic [LENGTH_BITS-1:0] rx_rem_nxt;

  i2cms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cms_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .req        (req_r),
    .cfg        (cfg),
    .tx_rem     (tx_rem_r),
    .rx_rem     (rx_rem_r),
    .res        (res),
    .tx_rem_nxt (tx_rem_nxt),
    .rx_rem_nxt (rx_rem_nxt)
  );

  // pipeline flow control
  assign advance   = !res_v_r || out_tready;
  assign fire      = req_v_r && advance;
  assign in_tready = !req_v_r || advance;
  assign req_v_nxt = in_tready ? in_tvalid : req_v_r;
  assign res_v_nxt = advance ? req_v_r : res_v_r;

  // control registers and byte counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r  <= 1'b0;
      res_v_r  <= 1'b0;
      tx_rem_r <= '0;
      rx_rem_r <= '0;
    end else begin
      req_v_r <= req_v_nxt;
      res_v_r <= res_v_nxt;
      if (fire) begin
        tx_rem_r <= tx_rem_nxt;
        rx_rem_r <= rx_rem_nxt;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_tready) begin
      req_r <= {op_t'(in_tuser[0]), status_t'(in_tuser[IN_TUSER_W-1:1]),
                in_tdata[BYTE_W-1:0], in_tdata[IN_TDATA_W-1:BYTE_W]};
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, res_r};

endmodule

/* sim/i2cms_action_monitor.sv */
// ----------------------------------------------------------------------------
// i2cms_action_monitor
// Watches the request and result streams of the I2C master status sequencer,
// predicts the controller actions of every accepted request and compares
// them field by field with the results in order.
// ----------------------------------------------------------------------------
module i2cms_action_monitor
  import i2cms_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_data[7:0], tx_data[15:8]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // operation[0], status_code[4:1]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // res_t fields, zero fill on top
  output int                     fail_count,
  output int                     outstanding
);

  // mirrored registers and transfer counters
  logic [ADDR_W-1:0]      addr_reg   = '0;
  logic [LEN_W-1:0]       tx_len_reg = '0;
  logic [LEN_W-1:0]       rx_len_reg = '0;
  logic [LENGTH_BITS-1:0] tx_left    = '0;
  logic [LENGTH_BITS-1:0] rx_left    = '0;

  res_t pending_actions[$];
  res_t got;
  res_t want;
  req_t req;
  int   results_seen = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string field, logic [31:0] seen, logic [31:0] wanted);
    if (fail_count < 100)
      $display("result %0d: %s is %0h, expected %0h", results_seen, field, seen, wanted);
    fail_count++;
  endtask

  // controller actions for one request, updating the counters
  function automatic res_t next_bus_actions(req_t r);
    res_t a;
    a = '0;
    a.error_kind = ERR_NONE;
    if (r.operation == OP_START) begin
      tx_left = LENGTH_BITS'(tx_len_reg);
      rx_left = LENGTH_BITS'(rx_len_reg);
      a.set_start = 1'b1;
    end else begin
      case (r.status_code)
        ST_START: begin
          // read bit once the write phase is used up
          a.bus_byte    = {addr_reg, (tx_left == '0)};
          a.write_byte  = 1'b1;
          a.clear_event = 1'b1;
        end
        ST_SLAW_NACK, ST_TDAT_NACK, ST_SLAR_NACK: begin
          a.set_stop    = 1'b1;
          a.clear_event = 1'b1;
          a.finished    = 1'b1;
          a.error_kind  = ERR_ACK;
        end
        ST_SLAW_ACK, ST_TDAT_ACK: begin
          if (tx_left != '0) begin
            a.bus_byte   = r.tx_data;
            a.write_byte = 1'b1;
            tx_left      = tx_left - 1'b1;
          end else if (rx_left != '0) begin
            // repeated start into the read phase
            a.set_stop  = 1'b1;
            a.set_start = 1'b1;
          end else begin
            a.set_stop = 1'b1;
            a.finished = 1'b1;
          end
          a.clear_event = 1'b1;
        end
        ST_SLAR_ACK, ST_RDAT_ACK: begin
          if (r.status_code == ST_RDAT_ACK) begin
            a.rx_byte  = r.rx_data;
            a.rx_valid = 1'b1;
            if (rx_left != '0) rx_left = rx_left - 1'b1;
          end
          // no acknowledge before the last byte
          if (rx_left == LENGTH_BITS'(1)) a.clear_ack = 1'b1;
          else a.set_ack = 1'b1;
          a.clear_event = 1'b1;
        end
        ST_RDAT_NACK: begin
          a.rx_byte  = r.rx_data;
          a.rx_valid = 1'b1;
          if (rx_left != '0) rx_left = rx_left - 1'b1;
          a.set_stop    = 1'b1;
          a.clear_event = 1'b1;
          a.finished    = 1'b1;
        end
        ST_ARB_LOST: begin
          a.clear_event = 1'b1;
          a.finished    = 1'b1;
          a.error_kind  = ERR_ARB;
        end
        ST_BUS_ERROR: begin
          a.clear_event = 1'b1;
          a.finished    = 1'b1;
          a.error_kind  = ERR_BUS;
        end
        default: ;
      endcase
    end
    return a;
  endfunction

  // register writes, prediction on requests, comparison on results
  always @(posedge clk) begin
    if (!rst_n) begin
      addr_reg   = '0;
      tx_len_reg = '0;
      rx_len_reg = '0;
      tx_left    = '0;
      rx_left    = '0;
      pending_actions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_SLAVE_ADDR: addr_reg   = cfg_wdata[ADDR_W-1:0];
          REG_TX_LENGTH:  tx_len_reg = cfg_wdata[LEN_W-1:0];
          REG_RX_LENGTH:  rx_len_reg = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        req.operation   = op_t'(in_tuser[0]);
        req.status_code = status_t'(in_tuser[4:1]);
        req.rx_data     = in_tdata[7:0];
        req.tx_data     = in_tdata[15:8];
        pending_actions.push_back(next_bus_actions(req));
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (pending_actions.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata, '0);
        end else begin
          want = pending_actions.pop_front();
          if (got.bus_byte !== want.bus_byte)
            report_mismatch("bus_byte", got.bus_byte, want.bus_byte);
          if (got.write_byte !== want.write_byte)
            report_mismatch("write_byte", got.write_byte, want.write_byte);
          if (got.set_start !== want.set_start)
            report_mismatch("set_start", got.set_start, want.set_start);
          if (got.set_stop !== want.set_stop)
            report_mismatch("set_stop", got.set_stop, want.set_stop);
          if (got.set_ack !== want.set_ack)
            report_mismatch("set_ack", got.set_ack, want.set_ack);
          if (got.clear_ack !== want.clear_ack)
            report_mismatch("clear_ack", got.clear_ack, want.clear_ack);
          if (got.clear_event !== want.clear_event)
            report_mismatch("clear_event", got.clear_event, want.clear_event);
          if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
          if (got.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
          if (got.finished !== want.finished)
            report_mismatch("finished", got.finished, want.finished);
          if (got.error_kind !== want.error_kind)
            report_mismatch("error_kind", got.error_kind, want.error_kind);
          if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0)
            report_mismatch("zero fill", out_tdata[OUT_TDATA_W-1:RES_W], '0);
        end
        results_seen++;
      end
    end
    outstanding <= pending_actions.size();
  end

endmodule

/* sim/i2c_master_status_sequencer_core_test.sv */
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer_core_test
// Drives start and status event requests through the sequencer: a directed
// walk through a full write-then-read transfer and every status code, then
// random transfers with injected errors and noise under several register
// settings, with random gaps on both streams. The action monitor checks.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer_core_test
  import i2cms_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 125;
  localparam int SEND_SIDE    = 0;
  localparam int TAKE_SIDE    = 1;

  logic                   clk        = 1'b1;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // rx_data[7:0], tx_data[15:8]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;  // operation[0], status_code[4:1]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // bus_byte[7:0], write_byte[8], set_start[9], set_stop[10], set_ack[11],
  // clear_ack[12], clear_event[13], rx_byte[21:14], rx_valid[22],
  // finished[23], error_kind[25:24], zero fill[31:26]
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int sent_count  = 0;

  // gap state of each side: length of the current stretch and whether it never idles
  int gap_run[2]  = '{0, 0};
  bit gap_calm[2] = '{1'b0, 1'b0};

  i2c_master_status_sequencer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  i2cms_action_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #2 clk = 1'b0;
    #2 clk = 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // gap before the next request or result, with stretches that never idle
  function automatic int draw_gap(int side);
    if (gap_run[side] == 0) begin
      gap_run[side]  = $urandom_range(5, 40);
      gap_calm[side] = ($urandom_range(0, 3) == 0);
    end
    gap_run[side]--;
    return gap_calm[side] ? 0 : $urandom_range(0, 11);
  endfunction

  // result side stalls
  initial begin
    int gap;
    forever begin
      gap = draw_gap(TAKE_SIDE);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // one request, returns at the edge it is taken
  task automatic send_req(op_t op, status_t st, logic [7:0] rxd, logic [7:0] txd);
    int gap;
    gap = draw_gap(SEND_SIDE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {st, op};
    in_tdata  <= {txd, rxd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_event(status_t st);
    send_req(OP_STATUS, st, 8'($urandom), 8'($urandom));
  endtask

  // wait until every result is back and the block is quiet
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(logic [6:0] addr, logic [15:0] tx_len, logic [15:0] rx_len);
    settle_idle();
    write_reg(REG_SLAVE_ADDR, CFG_DATA_W'(addr));
    write_reg(REG_TX_LENGTH, tx_len);
    write_reg(REG_RX_LENGTH, rx_len);
  endtask

  // status event that may be preceded by an ignored code or replaced by an error
  task automatic flow_event(status_t st, output bit aborted);
    aborted = 1'b0;
    if ($urandom_range(0, 24) == 0)
      send_event(status_t'(4'(ST_OTHER) + 4'($urandom_range(0, 4))));
    if ($urandom_range(0, 29) == 0) begin
      aborted = 1'b1;
      case ($urandom_range(0, 4))
        0: send_event(ST_SLAW_NACK);
        1: send_event(ST_TDAT_NACK);
        2: send_event(ST_SLAR_NACK);
        3: send_event(ST_ARB_LOST);
        default: send_event(ST_BUS_ERROR);
      endcase
    end else begin
      send_event(st);
    end
  endtask

  // a well-formed write-then-read transfer with random content
  task automatic run_transfer(int n_tx, int n_rx);
    bit ab;
    send_req(OP_START, status_t'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
    flow_event(ST_START, ab);
    if (ab) return;
    if (n_tx > 0 || n_rx == 0) begin
      flow_event(ST_SLAW_ACK, ab);
      if (ab) return;
      repeat (n_tx) begin
        flow_event(ST_TDAT_ACK, ab);
        if (ab) return;
      end
      if (n_rx == 0) return;
      flow_event(ST_START, ab);
      if (ab) return;
    end
    flow_event(ST_SLAR_ACK, ab);
    if (ab) return;
    repeat (n_rx - 1) begin
      flow_event(ST_RDAT_ACK, ab);
      if (ab) return;
    end
    flow_event(ST_RDAT_NACK, ab);
  endtask

  // stimulus and verdict
  initial begin
    logic [6:0]  addr;
    logic [15:0] tx_len;
    logic [15:0] rx_len;
    int          phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // event before any start or register write
    send_req(OP_STATUS, ST_START, 8'h00, 8'h00);

    // full write-then-read transfer, then the remaining codes
    load_regs(7'h7F, 16'd2, 16'd2);
    send_req(OP_START, ST_BUS_ERROR, 8'hFF, 8'hFF);
    send_req(OP_STATUS, ST_START, 8'h00, 8'h00);
    send_req(OP_STATUS, ST_SLAW_ACK, 8'hFF, 8'h00);
    send_req(OP_STATUS, ST_TDAT_ACK, 8'h00, 8'hFF);
    send_req(OP_STATUS, ST_TDAT_ACK, 8'h5A, 8'hA5);
    send_req(OP_STATUS, ST_START, 8'hFF, 8'hFF);
    send_req(OP_STATUS, ST_SLAR_ACK, 8'h3C, 8'hC3);
    send_req(OP_STATUS, ST_RDAT_ACK, 8'hFF, 8'h00);
    send_req(OP_STATUS, ST_RDAT_NACK, 8'h00, 8'hFF);
    // receive count already at zero
    send_req(OP_STATUS, ST_RDAT_ACK, 8'hA5, 8'h5A);
    send_req(OP_STATUS, ST_RDAT_NACK, 8'h81, 8'h18);
    send_req(OP_STATUS, ST_SLAW_ACK, 8'h42, 8'h24);
    send_req(OP_STATUS, ST_SLAW_NACK, 8'h11, 8'h22);
    send_req(OP_STATUS, ST_TDAT_NACK, 8'h33, 8'h44);
    send_req(OP_STATUS, ST_SLAR_NACK, 8'h55, 8'h66);
    send_req(OP_STATUS, ST_ARB_LOST, 8'h77, 8'h88);
    send_req(OP_STATUS, ST_BUS_ERROR, 8'h99, 8'hAA);
    send_req(OP_STATUS, ST_OTHER, 8'hBB, 8'hCC);
    for (int k = 1; k <= 4; k++)
      send_req(OP_STATUS, status_t'(4'(ST_OTHER) + 4'(k)), 8'hDD, 8'hEE);

    // random phases, the first four at the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      addr   = 7'($urandom_range(0, 127));
      tx_len = 16'($urandom_range(0, 5));
      rx_len = 16'($urandom_range(0, 5));
      case (ph)
        0: begin addr = 7'h7F; tx_len = 16'hFFFF; rx_len = 16'hFFFF; end
        1: begin addr = 7'h00; tx_len = 16'h0000; rx_len = 16'h0000; end
        2: begin tx_len = 16'h0000; rx_len = 16'hFFFF; end
        3: begin tx_len = 16'hFFFF; rx_len = 16'h0000; end
        default: ;
      endcase
      load_regs(addr, tx_len, rx_len);
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: any kind, any code
          repeat ($urandom_range(1, 6))
            send_req(op_t'($urandom_range(0, 1)), status_t'($urandom_range(0, 15)),
                     8'($urandom), 8'($urandom));
        end else begin
          run_transfer((tx_len > 6) ? $urandom_range(1, 6) : int'(tx_len),
                       (rx_len > 6) ? $urandom_range(1, 6) : int'(rx_len));
        end
      end
    end

    settle_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
